// ===== rtl/rbst_pkg.sv =====
// Shared types and constants for the ray box slab test unit.
// No dependencies.
package rbst_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ADDR_W = 3;
	localparam logic REG_EPS = 1'b0;
	localparam logic [15:0] EPS_RESET = 16'd7;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [16:0] entry_fraction;
	} rsp_t;

	typedef struct packed {
		logic signed [32:0] d;
		logic signed [32:0] nlo;
		logic signed [32:0] nhi;
		logic               pok;
	} axis_front_t;

	typedef struct packed {
		logic par;
		logic pok;
	} axis_ctl_t;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_ONE,
		CLS_DIV
	} ratio_cls_t;

endpackage

// ===== rtl/rbst_axis_setup.sv =====
// Per-axis classification: parallel test, divisor magnitude, ratio class.
// Depends on rbst_pkg.
module rbst_axis_setup (
	input  rbst_pkg::axis_front_t  front,
	input  logic [15:0]            eps,
	output rbst_pkg::axis_ctl_t    ctl,
	output logic [31:0]            den,
	output rbst_pkg::ratio_cls_t   cls_lo,
	output rbst_pkg::ratio_cls_t   cls_hi,
	output logic [31:0]            rem_lo,
	output logic [31:0]            rem_hi
);

	logic [32:0] neg_d;
	logic [32:0] neg_lo;
	logic [32:0] neg_hi;
	logic [31:0] mag;
	logic        opp_lo;
	logic        opp_hi;

	always_comb begin
		neg_d  = 33'(-front.d);
		neg_lo = 33'(-front.nlo);
		neg_hi = 33'(-front.nhi);
		mag    = front.d[32] ? neg_d[31:0] : front.d[31:0];
		rem_lo = front.nlo[32] ? neg_lo[31:0] : front.nlo[31:0];
		rem_hi = front.nhi[32] ? neg_hi[31:0] : front.nhi[31:0];
		den    = mag;
		ctl.par = (front.d == 33'sd0) || (mag < {16'd0, eps});
		ctl.pok = front.pok;
		opp_lo = (front.nlo != 33'sd0) && (front.nlo[32] != front.d[32]);
		opp_hi = (front.nhi != 33'sd0) && (front.nhi[32] != front.d[32]);
		if (opp_lo) begin
			cls_lo = rbst_pkg::CLS_ZERO;
		end else if (rem_lo >= mag) begin
			cls_lo = rbst_pkg::CLS_ONE;
		end else begin
			cls_lo = rbst_pkg::CLS_DIV;
		end
		if (opp_hi) begin
			cls_hi = rbst_pkg::CLS_ZERO;
		end else if (rem_hi >= mag) begin
			cls_hi = rbst_pkg::CLS_ONE;
		end else begin
			cls_hi = rbst_pkg::CLS_DIV;
		end
	end

endmodule

// ===== rtl/rbst_div_step.sv =====
// One restoring division step: shift remainder, compare, subtract.
// No dependencies.
module rbst_div_step (
	input  logic [31:0] rem,
	input  logic [31:0] den,
	output logic [31:0] rem_nxt,
	output logic        qbit
);

	logic [32:0] r2;
	logic [32:0] diff;

	always_comb begin
		r2      = {rem, 1'b0};
		diff    = r2 - {1'b0, den};
		qbit    = r2 >= {1'b0, den};
		rem_nxt = qbit ? diff[31:0] : r2[31:0];
	end

endmodule

// ===== rtl/rbst_slab_merge.sv =====
// Slab interval merge: order fractions, narrow interval, form hit and entry.
// Depends on rbst_pkg.
module rbst_slab_merge #(
	parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
	input  rbst_pkg::axis_ctl_t  ctl [3],
	input  rbst_pkg::ratio_cls_t cls [6],
	input  logic [FRAC_BITS-1:0] quo [6],
	output rbst_pkg::rsp_t       rsp
);

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic [FRAC_BITS:0] t   [6];
	logic [FRAC_BITS:0] tlo [3];
	logic [FRAC_BITS:0] thi [3];
	logic [FRAC_BITS:0] tmin;
	logic [FRAC_BITS:0] tmax;
	logic               miss;
	logic [16:0]        ent;

	always_comb begin
		for (int r = 0; r < 6; r++) begin
			case (cls[r])
				rbst_pkg::CLS_ZERO: t[r] = '0;
				rbst_pkg::CLS_ONE:  t[r] = ONE;
				rbst_pkg::CLS_DIV:  t[r] = {1'b0, quo[r]};
				default:            t[r] = '0;
			endcase
		end
		tmin = '0;
		tmax = ONE;
		miss = 1'b0;
		for (int a = 0; a < 3; a++) begin
			if (t[2*a] > t[2*a+1]) begin
				tlo[a] = t[2*a+1];
				thi[a] = t[2*a];
			end else begin
				tlo[a] = t[2*a];
				thi[a] = t[2*a+1];
			end
			if (ctl[a].par) begin
				if (!ctl[a].pok) miss = 1'b1;
			end else begin
				if (tlo[a] > tmin) tmin = tlo[a];
				if (thi[a] < tmax) tmax = thi[a];
			end
		end
		if (tmin > tmax) miss = 1'b1;
	end

	generate
		if (FRAC_BITS >= 16) begin : g_shr
			assign ent = 17'(tmin >> (FRAC_BITS - 16));
		end else begin : g_shl
			assign ent = {tmin, {(16 - FRAC_BITS){1'b0}}};
		end
	endgenerate

	always_comb begin
		rsp.hit            = !miss;
		rsp.entry_fraction = miss ? 17'd0 : ent;
	end

endmodule

// ===== rtl/ray_box_slab_test_unit.sv =====
// Top level of the ray box slab test unit: front stage, setup, divider
// pipeline, merge and output register. Depends on rbst_pkg and all rbst_ modules.
//
// Accepts one segment-versus-box request every cycle unless backpressure stalls a
// full pipeline. The pipeline has FRAC_BITS+3 register stages (19 at the default
// of 16). The differences are registered at the accepting edge. One stage
// classifies each axis. FRAC_BITS stages run six restoring dividers, one quotient
// bit per stage. One stage merges the slabs into the output register. Each stage
// holds independently, so bubbles close up under backpressure. parallel_epsilon
// sits at byte address 0 and resets to 7; change it only while the unit is empty.
module ray_box_slab_test_unit #(
	parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  rbst_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output rbst_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rbst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int NST = FRAC_BITS + 3;
	localparam int OUT = FRAC_BITS + 2;

	logic [15:0]    eps_q;
	logic [NST-1:0] vld_q;
	logic [NST:0]   rdy;

	logic signed [31:0] s_in  [3];
	logic signed [31:0] e_in  [3];
	logic signed [31:0] lo_in [3];
	logic signed [31:0] hi_in [3];

	rbst_pkg::axis_front_t front_c  [3];
	rbst_pkg::axis_front_t front_s1 [3];

	rbst_pkg::axis_ctl_t  ctl_c [3];
	logic [31:0]          den_c [3];
	rbst_pkg::ratio_cls_t cls_c [6];
	logic [31:0]          rem_c [6];

	rbst_pkg::axis_ctl_t  ctl_s [0:FRAC_BITS][3];
	logic [31:0]          den_s [0:FRAC_BITS][3];
	rbst_pkg::ratio_cls_t cls_s [0:FRAC_BITS][6];
	logic [31:0]          rem_s [0:FRAC_BITS][6];
	logic [FRAC_BITS-1:0] quo_s [0:FRAC_BITS][6];

	rbst_pkg::rsp_t rsp_c;
	rbst_pkg::rsp_t rsp_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rbst_pkg::REG_EPS) ? {16'd0, eps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= rbst_pkg::EPS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == rbst_pkg::REG_EPS) begin
			eps_q <= pwdata[15:0];
		end
	end

	always_comb begin
		rdy[NST] = rsp_ready;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign req_ready = rdy[0];
	assign rsp_valid = vld_q[OUT];
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		s_in[0]  = req.start_x;   s_in[1]  = req.start_y;   s_in[2]  = req.start_z;
		e_in[0]  = req.end_x;     e_in[1]  = req.end_y;     e_in[2]  = req.end_z;
		lo_in[0] = req.box_min_x; lo_in[1] = req.box_min_y; lo_in[2] = req.box_min_z;
		hi_in[0] = req.box_max_x; hi_in[1] = req.box_max_y; hi_in[2] = req.box_max_z;
		for (int a = 0; a < 3; a++) begin
			front_c[a].d   = 33'(e_in[a]) - 33'(s_in[a]);
			front_c[a].nlo = 33'(lo_in[a]) - 33'(s_in[a]);
			front_c[a].nhi = 33'(hi_in[a]) - 33'(s_in[a]);
			front_c[a].pok = (s_in[a] >= lo_in[a]) && (s_in[a] <= hi_in[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			front_s1 <= front_c;
		end
	end

	generate
		for (genvar a = 0; a < 3; a++) begin : g_axis
			rbst_axis_setup u_setup (
				.front  (front_s1[a]),
				.eps    (eps_q),
				.ctl    (ctl_c[a]),
				.den    (den_c[a]),
				.cls_lo (cls_c[2*a]),
				.cls_hi (cls_c[2*a+1]),
				.rem_lo (rem_c[2*a]),
				.rem_hi (rem_c[2*a+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			ctl_s[0] <= ctl_c;
			den_s[0] <= den_c;
			cls_s[0] <= cls_c;
			rem_s[0] <= rem_c;
			for (int r = 0; r < 6; r++) begin
				quo_s[0][r] <= '0;
			end
		end
	end

	generate
		for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
			logic [31:0] rn [6];
			logic        qb [6];
			for (genvar r = 0; r < 6; r++) begin : g_ratio
				rbst_div_step u_step (
					.rem     (rem_s[k-1][r]),
					.den     (den_s[k-1][r/2]),
					.rem_nxt (rn[r]),
					.qbit    (qb[r])
				);
			end
			always_ff @(posedge clk) begin
				if (rdy[k+1]) begin
					ctl_s[k] <= ctl_s[k-1];
					den_s[k] <= den_s[k-1];
					cls_s[k] <= cls_s[k-1];
					for (int r = 0; r < 6; r++) begin
						rem_s[k][r] <= rn[r];
						quo_s[k][r] <= {quo_s[k-1][r][FRAC_BITS-2:0], qb[r]};
					end
				end
			end
		end
	endgenerate

	rbst_slab_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.ctl (ctl_s[FRAC_BITS]),
		.cls (cls_s[FRAC_BITS]),
		.quo (quo_s[FRAC_BITS]),
		.rsp (rsp_c)
	);

	always_ff @(posedge clk) begin
		if (rdy[OUT]) begin
			rsp_q <= rsp_c;
		end
	end

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.entry_fraction == 17'd0)
		else $error("miss with nonzero entry fraction");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_fraction <= 17'h10000)
		else $error("entry fraction above one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> vld_q[0])
		else $error("accepted request not captured");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q) && !rsp_ready |-> !req_ready)
		else $error("request taken into a full stalled pipeline");
`endif

endmodule
